@@ src/conv3x3_replicate_border_top_assert.svh @@
// Assertion macros for the 3x3 convolution block.
`ifndef CONV3X3_REPLICATE_BORDER_TOP_ASSERT_SVH
`define CONV3X3_REPLICATE_BORDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define C3RB_CHK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c3rb check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define C3RB_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c3rb check failed");

`endif

@@ src/c3rb_pkg.sv @@
// Shared types and constants of the 3x3 convolution block.
`default_nettype none

package c3rb_pkg;

    localparam int PIX_W     = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 35;
    localparam int COL_OUT_W = 10;
    localparam int ROW_OUT_W = 12;
    localparam int KROW_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int SIZE_W    = 17;
    localparam int TAPS      = 9;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_TOP    = 3'd0,
        REG_KERNEL_MID    = 3'd1,
        REG_KERNEL_BOTTOM = 3'd2,
        REG_SOURCE_WIDTH  = 3'd3,
        REG_SOURCE_HEIGHT = 3'd4,
        REG_DEST_WIDTH    = 3'd5,
        REG_DEST_HEIGHT   = 3'd6
    } cfg_reg_t;

    typedef logic signed [PIX_W-1:0]  pix_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Position and flags that travel with one result through the MAC
    typedef struct packed {
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic                 last;
        logic                 eof;
    } tag_t;

    // Coefficient kc (0 left, 2 right) of one packed kernel row
    function automatic coef_t coef_of(input logic [KROW_W-1:0] krow, input int kc);
        return coef_t'(krow[COEF_W*kc +: COEF_W]);
    endfunction

endpackage

`default_nettype wire

@@ src/c3rb_ram.sv @@
// Generic single-write, registered-read RAM.
`default_nettype none

module c3rb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read old contents on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/c3rb_mac.sv @@
// Nine-tap multiply stage and adder stage with their own handshake.
`default_nettype none

module c3rb_mac (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire c3rb_pkg::pix_t       taps  [c3rb_pkg::TAPS],
    input  wire c3rb_pkg::coef_t      coefs [c3rb_pkg::TAPS],
    input  wire c3rb_pkg::tag_t       tag_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output c3rb_pkg::sum_t            sum,
    output c3rb_pkg::tag_t            tag_out
);

    logic            d_v_reg;
    c3rb_pkg::prod_t prod_reg [c3rb_pkg::TAPS];
    c3rb_pkg::tag_t  d_tag_reg;
    logic            e_v_reg;
    c3rb_pkg::sum_t  sum_reg;
    c3rb_pkg::tag_t  e_tag_reg;
    c3rb_pkg::sum_t  sum_next;
    logic            e_load;
    logic            d_load;

    assign e_load   = d_v_reg && (!e_v_reg || out_ready);
    assign in_ready = !d_v_reg || !e_v_reg || out_ready;
    assign d_load   = in_valid && in_ready;

    // Hold the valid flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            if (d_load)
            begin
                d_v_reg <= 1'b1;
            end
            else if (e_load)
            begin
                d_v_reg <= 1'b0;
            end
            if (e_load)
            begin
                e_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                e_v_reg <= 1'b0;
            end
        end
    end

    // Register the nine products
    always_ff @(posedge clk)
    begin
        if (d_load)
        begin
            for (int i = 0; i < c3rb_pkg::TAPS; i++)
            begin
                prod_reg[i] <= c3rb_pkg::prod_t'(taps[i] * coefs[i]);
            end
            d_tag_reg <= tag_in;
        end
    end

    // Add the products exactly
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < c3rb_pkg::TAPS; i++)
        begin
            sum_next = sum_next + c3rb_pkg::sum_t'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_load)
        begin
            sum_reg   <= sum_next;
            e_tag_reg <= d_tag_reg;
        end
    end

    assign out_valid = e_v_reg;
    assign sum       = sum_reg;
    assign tag_out   = e_tag_reg;

endmodule

`default_nettype wire

@@ src/conv3x3_replicate_border_top.sv @@
// Streaming 3x3 convolution with replicated borders, top level.
`default_nettype none
`include "conv3x3_replicate_border_top_assert.svh"

// Pixels enter in raster order, one per clock when the result side keeps up.
// Each pixel yields zero to four results, which leave one per clock while out_ready
// is held high; the result emitter works through one pixel's results at a time, and
// that emitter sets the sustained rate. A request reaches its first result through
// the registered line-store read, window update, multiply and add, in order. The
// line store is two rows of MAX_WIDTH pixels in two RAMs, read at the current
// column every request; it needs no clearing after reset, since clamping at
// the top edge never uses unwritten rows. Configuration is taken at once, but
// must only be written while the block is idle.
module conv3x3_replicate_border_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [c3rb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [c3rb_pkg::KROW_W-1:0]           cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [c3rb_pkg::PIX_W-1:0]     pixel,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [c3rb_pkg::SUM_W-1:0]          value,
    output logic [c3rb_pkg::COL_OUT_W-1:0]             out_col,
    output logic [c3rb_pkg::ROW_OUT_W-1:0]             out_row,
    output logic                                       last_of_run,
    output logic                                       end_of_frame
);

    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SZ  = c3rb_pkg::SIZE_W;
    localparam int OCW = c3rb_pkg::COL_OUT_W;
    localparam int ORW = c3rb_pkg::ROW_OUT_W;
    localparam logic [SZ-1:0] MAXW = SZ'(MAX_WIDTH);
    localparam logic [SZ-1:0] MAXH = SZ'(MAX_HEIGHT);
    localparam logic [SZ-1:0] ONE  = SZ'(1);
    localparam logic [SZ-1:0] TWO  = SZ'(2);

    // Configuration registers
    logic [c3rb_pkg::KROW_W-1:0] kern_reg [3];
    logic [10:0] src_w_reg;
    logic [12:0] src_h_reg;
    logic [10:0] dst_w_reg;
    logic [12:0] dst_h_reg;

    // Input position
    logic [CW-1:0] in_col_reg;
    logic [RW-1:0] in_row_reg;

    // Stage B: request waiting for line-store data
    logic                 b_v_reg;
    c3rb_pkg::pix_t       b_pix_reg;
    logic                 b_par_reg;
    logic [CW-1:0]        b_x_reg;
    logic [RW-1:0]        b_y_reg;
    logic [3:0]           b_mask_reg;
    logic [3:0]           b_eof_reg;
    logic [3:0]           b_flag_reg;

    // Stage C: window and pending results of one request
    c3rb_pkg::pix_t       win_reg [3][3];
    logic [3:0]           c_mask_reg;
    logic [3:0]           c_eof_reg;
    logic [CW-1:0]        c_x_reg;
    logic [RW-1:0]        c_y_reg;
    logic [3:0]           c_flag_reg;

    logic [SZ-1:0] w_eff, h_eff, dw_eff, dh_eff, wm1, hm1, dwm1, dhm1;
    logic [SZ-1:0] sw_ext, sh_ext, dw_ext, dh_ext;
    logic [SZ-1:0] x_ext, y_ext, xm1, ym1, col_ext, row_ext;
    logic          xlast, ylast, x_ge1, y_ge1;
    logic [3:0]    mask_next, eof_next, flag_next;
    logic          accept;
    logic          c_free;
    logic          bc_go;
    logic          issue;
    logic          mac_ready;
    logic [3:0]    pick_oh;
    logic [1:0]    pick_idx;
    logic [3:0]    rest;
    logic [1:0]    rsel [3];
    logic [1:0]    csel [3];
    c3rb_pkg::pix_t  taps  [c3rb_pkg::TAPS];
    c3rb_pkg::coef_t coefs [c3rb_pkg::TAPS];
    c3rb_pkg::tag_t  tag_in, tag_out;
    c3rb_pkg::sum_t  sum;
    logic [CW-1:0] emit_col;
    logic [RW-1:0] emit_row;
    logic [c3rb_pkg::PIX_W-1:0] bank0_rdata, bank1_rdata;

    // Pick one of three window entries
    function automatic c3rb_pkg::pix_t pick3(input c3rb_pkg::pix_t a, input c3rb_pkg::pix_t b,
                                             input c3rb_pkg::pix_t c, input logic [1:0] sel);
        c3rb_pkg::pix_t r;
        unique case (sel)
            2'd0:    r = a;
            2'd1:    r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kern_reg[0] <= '0;
            kern_reg[1] <= 48'h0000_4000_0000;
            kern_reg[2] <= '0;
            src_w_reg   <= 11'd1024;
            src_h_reg   <= 13'd4096;
            dst_w_reg   <= 11'd1024;
            dst_h_reg   <= 13'd4096;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                c3rb_pkg::REG_KERNEL_TOP:    kern_reg[0] <= cfg_data;
                c3rb_pkg::REG_KERNEL_MID:    kern_reg[1] <= cfg_data;
                c3rb_pkg::REG_KERNEL_BOTTOM: kern_reg[2] <= cfg_data;
                c3rb_pkg::REG_SOURCE_WIDTH:  src_w_reg   <= cfg_data[10:0];
                c3rb_pkg::REG_SOURCE_HEIGHT: src_h_reg   <= cfg_data[12:0];
                c3rb_pkg::REG_DEST_WIDTH:    dst_w_reg   <= cfg_data[10:0];
                c3rb_pkg::REG_DEST_HEIGHT:   dst_h_reg   <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Clamp sizes and the current position
    always_comb
    begin
        sw_ext = SZ'(src_w_reg);
        sh_ext = SZ'(src_h_reg);
        dw_ext = SZ'(dst_w_reg);
        dh_ext = SZ'(dst_h_reg);
        w_eff  = (sw_ext == '0) ? ONE : ((sw_ext > MAXW) ? MAXW : sw_ext);
        h_eff  = (sh_ext == '0) ? ONE : ((sh_ext > MAXH) ? MAXH : sh_ext);
        dw_eff = (dw_ext < w_eff) ? dw_ext : w_eff;
        dh_eff = (dh_ext < h_eff) ? dh_ext : h_eff;
        wm1    = w_eff - ONE;
        hm1    = h_eff - ONE;
        dwm1   = dw_eff - ONE;
        dhm1   = dh_eff - ONE;
        x_ext  = (SZ'(in_col_reg) > wm1) ? wm1 : SZ'(in_col_reg);
        y_ext  = (SZ'(in_row_reg) > hm1) ? hm1 : SZ'(in_row_reg);
        xm1    = x_ext - ONE;
        ym1    = y_ext - ONE;
        xlast  = (x_ext == wm1);
        ylast  = (y_ext == hm1);
        x_ge1  = (x_ext != '0);
        y_ge1  = (y_ext != '0);
        // Results in raster order: (y-1,x-1), (y-1,x), (y,x-1), (y,x)
        mask_next[0] = y_ge1 && x_ge1 && (ym1 < dh_eff) && (xm1 < dw_eff);
        mask_next[1] = y_ge1 && xlast && (ym1 < dh_eff) && (x_ext < dw_eff);
        mask_next[2] = ylast && x_ge1 && (y_ext < dh_eff) && (xm1 < dw_eff);
        mask_next[3] = ylast && xlast && (y_ext < dh_eff) && (x_ext < dw_eff);
        eof_next[0]  = (ym1 == dhm1) && (xm1 == dwm1);
        eof_next[1]  = (ym1 == dhm1) && (x_ext == dwm1);
        eof_next[2]  = (y_ext == dhm1) && (xm1 == dwm1);
        eof_next[3]  = (y_ext == dhm1) && (x_ext == dwm1);
        // Border flags: row is zero, row at least two, same for column
        flag_next[0] = !y_ge1;
        flag_next[1] = (y_ext >= TWO);
        flag_next[2] = !x_ge1;
        flag_next[3] = (x_ext >= TWO);
    end

    assign in_ready = !b_v_reg || c_free;
    assign accept   = in_valid && in_ready;
    assign bc_go    = b_v_reg && c_free;

    // Advance the raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end
        else if (accept)
        begin
            if (xlast)
            begin
                in_col_reg <= '0;
                in_row_reg <= ylast ? '0 : RW'(y_ext + ONE);
            end
            else
            begin
                in_col_reg <= CW'(x_ext + ONE);
                in_row_reg <= RW'(y_ext);
            end
        end
    end

    // Line store: one RAM per row parity
    c3rb_ram #(.WIDTH(c3rb_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_bank0 (
        .clk   (clk),
        .we    (accept && !y_ext[0]),
        .waddr (CW'(x_ext)),
        .wdata (pixel),
        .re    (accept),
        .raddr (CW'(x_ext)),
        .rdata (bank0_rdata)
    );

    c3rb_ram #(.WIDTH(c3rb_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_bank1 (
        .clk   (clk),
        .we    (accept && y_ext[0]),
        .waddr (CW'(x_ext)),
        .wdata (pixel),
        .re    (accept),
        .raddr (CW'(x_ext)),
        .rdata (bank1_rdata)
    );

    // Stage B valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (accept)
        begin
            b_v_reg <= 1'b1;
        end
        else if (bc_go)
        begin
            b_v_reg <= 1'b0;
        end
    end

    // Stage B payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_pix_reg  <= pixel;
            b_par_reg  <= y_ext[0];
            b_x_reg    <= CW'(x_ext);
            b_y_reg    <= RW'(y_ext);
            b_mask_reg <= mask_next;
            b_eof_reg  <= eof_next;
            b_flag_reg <= flag_next;
        end
    end

    // Emitter: lowest pending result first
    always_comb
    begin
        pick_oh  = 4'b0000;
        pick_idx = 2'd0;
        priority if (c_mask_reg[0])
        begin
            pick_oh  = 4'b0001;
            pick_idx = 2'd0;
        end
        else if (c_mask_reg[1])
        begin
            pick_oh  = 4'b0010;
            pick_idx = 2'd1;
        end
        else if (c_mask_reg[2])
        begin
            pick_oh  = 4'b0100;
            pick_idx = 2'd2;
        end
        else if (c_mask_reg[3])
        begin
            pick_oh  = 4'b1000;
            pick_idx = 2'd3;
        end
    end

    assign rest   = c_mask_reg & ~pick_oh;
    assign issue  = (c_mask_reg != 4'b0000) && mac_ready;
    assign c_free = (c_mask_reg == 4'b0000) || (issue && (rest == 4'b0000));

    // Shift the window and load the next request's results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_mask_reg <= '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (bc_go)
        begin
            c_mask_reg <= b_mask_reg;
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= b_par_reg ? bank1_rdata : bank0_rdata;
            win_reg[1][2] <= b_par_reg ? bank0_rdata : bank1_rdata;
            win_reg[2][2] <= b_pix_reg;
        end
        else if (issue)
        begin
            c_mask_reg <= rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bc_go)
        begin
            c_eof_reg  <= b_eof_reg;
            c_x_reg    <= b_x_reg;
            c_y_reg    <= b_y_reg;
            c_flag_reg <= b_flag_reg;
        end
    end

    // Clamp the window rows and columns for the chosen result
    always_comb
    begin
        rsel[0] = pick_idx[1] ? (c_flag_reg[0] ? 2'd2 : 2'd1) : (c_flag_reg[1] ? 2'd0 : 2'd1);
        rsel[1] = pick_idx[1] ? 2'd2 : 2'd1;
        rsel[2] = 2'd2;
        csel[0] = pick_idx[0] ? (c_flag_reg[2] ? 2'd2 : 2'd1) : (c_flag_reg[3] ? 2'd0 : 2'd1);
        csel[1] = pick_idx[0] ? 2'd2 : 2'd1;
        csel[2] = 2'd2;
        for (int kr = 0; kr < 3; kr++)
        begin
            for (int kc = 0; kc < 3; kc++)
            begin
                taps[kr*3+kc] = pick3(
                    pick3(win_reg[0][0], win_reg[1][0], win_reg[2][0], rsel[kr]),
                    pick3(win_reg[0][1], win_reg[1][1], win_reg[2][1], rsel[kr]),
                    pick3(win_reg[0][2], win_reg[1][2], win_reg[2][2], rsel[kr]),
                    csel[kc]);
                coefs[kr*3+kc] = c3rb_pkg::coef_of(kern_reg[kr], kc);
            end
        end
        col_ext  = pick_idx[0] ? SZ'(c_x_reg) : SZ'(c_x_reg) - ONE;
        row_ext  = pick_idx[1] ? SZ'(c_y_reg) : SZ'(c_y_reg) - ONE;
        emit_col = CW'(col_ext);
        emit_row = RW'(row_ext);
        tag_in.col  = OCW'(emit_col);
        tag_in.row  = ORW'(emit_row);
        tag_in.last = (rest == 4'b0000);
        tag_in.eof  = |(c_eof_reg & pick_oh);
    end

    c3rb_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue),
        .in_ready  (mac_ready),
        .taps      (taps),
        .coefs     (coefs),
        .tag_in    (tag_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sum       (sum),
        .tag_out   (tag_out)
    );

    assign value        = sum;
    assign out_col      = tag_out.col;
    assign out_row      = tag_out.row;
    assign last_of_run  = tag_out.last;
    assign end_of_frame = tag_out.eof;

    // The frame's last output is always the final result of its request
    `C3RB_CHK_IMP(a_eof_is_last, out_valid && end_of_frame, last_of_run)
    // Input stalls only behind a waiting request
    `C3RB_CHK_IMP(a_stall_cause, !in_ready, b_v_reg && !c_free)
    // Exactly one pending result is chosen
    `C3RB_CHK_IMP(a_one_pick, c_mask_reg != 4'b0000, $onehot(pick_oh))
    // An issued result leaves the pending set
    `C3RB_CHK_NEXT(a_issue_drop, issue && !bc_go, (c_mask_reg & $past(pick_oh)) == 4'b0000)

endmodule

`default_nettype wire

@@ tb/sv/tb_conv3x3_replicate_border_top.sv @@
// Self-checking testbench for the streaming 3x3 replicated-border convolution.
`default_nettype none

module tb_conv3x3_replicate_border_top;

    localparam int MAXW       = 1024;
    localparam int MAXH       = 4096;
    localparam int DRAIN      = 16;
    localparam int CYCLE_CAP  = 1000000;
    localparam int RAND_ITEMS = 300;
    localparam int EDGE_ITEMS = 40;

    typedef struct {
        logic signed [c3rb_pkg::SUM_W-1:0] value;
        logic [c3rb_pkg::COL_OUT_W-1:0]    col;
        logic [c3rb_pkg::ROW_OUT_W-1:0]    row;
        logic                              last;
        logic                              eof;
    } conv_result_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [c3rb_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [c3rb_pkg::KROW_W-1:0]         cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [c3rb_pkg::PIX_W-1:0]   pixel;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [c3rb_pkg::SUM_W-1:0]   value;
    logic [c3rb_pkg::COL_OUT_W-1:0]      out_col;
    logic [c3rb_pkg::ROW_OUT_W-1:0]      out_row;
    logic                                last_of_run;
    logic                                end_of_frame;

    conv3x3_replicate_border_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready), .value(value),
        .out_col(out_col), .out_row(out_row),
        .last_of_run(last_of_run), .end_of_frame(end_of_frame)
    );

    // Shadow of the block's registers and stream state
    logic [c3rb_pkg::KROW_W-1:0]       krow [3];
    int                                src_w, src_h, dst_w, dst_h;
    logic signed [c3rb_pkg::PIX_W-1:0] lstore [2*MAXW];
    logic signed [c3rb_pkg::PIX_W-1:0] win [3][3];
    int                                pcol, prow;

    logic signed [c3rb_pkg::PIX_W-1:0] pixel_q [$];
    conv_result_t                      conv_expect_q [$];
    int                                errors;
    int                                cycles;
    bit                                calm;
    int                                in_gap, out_stall;

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int gap_draw();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int size_eff(int v, int maxv);
        return v == 0 ? 1 : (v > maxv ? maxv : v);
    endfunction

    // Advance the shadow by one pixel and queue the sums it completes
    task automatic conv_predict(input logic signed [c3rb_pkg::PIX_W-1:0] pix);
        int w, h, dw, dh, x, y, nr, nc, wr, wc, r, c, n;
        int rows [2];
        int cols [2];
        longint sum;
        conv_result_t res;
        logic signed [c3rb_pkg::COEF_W-1:0] cf;
        w  = size_eff(src_w, MAXW);
        h  = size_eff(src_h, MAXH);
        dw = dst_w < w ? dst_w : w;
        dh = dst_h < h ? dst_h : h;
        if (pcol > w - 1) pcol = w - 1;
        if (prow > h - 1) prow = h - 1;
        x = pcol;
        y = prow;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = lstore[(prow & 1) * MAXW + pcol];
        win[1][2] = lstore[((prow + 1) & 1) * MAXW + pcol];
        win[2][2] = pix;
        lstore[(prow & 1) * MAXW + pcol] = pix;
        nr = 0;
        nc = 0;
        if (y >= 1) rows[nr++] = y - 1;
        if (y == h - 1) rows[nr++] = y;
        if (x >= 1) cols[nc++] = x - 1;
        if (x == w - 1) cols[nc++] = x;
        n = 0;
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                r = rows[i];
                c = cols[j];
                if (r < dh && c < dw)
                begin
                    sum = 0;
                    for (int kr = 0; kr < 3; kr++)
                    begin
                        wr = clamp_int(clamp_int(r + kr - 1, 0, h - 1) - (y - 2), 0, 2);
                        for (int kc = 0; kc < 3; kc++)
                        begin
                            wc = clamp_int(clamp_int(c + kc - 1, 0, w - 1) - (x - 2), 0, 2);
                            cf = krow[kr][16*kc +: 16];
                            sum += longint'(win[wr][wc]) * longint'(cf);
                        end
                    end
                    res.value = sum[c3rb_pkg::SUM_W-1:0];
                    res.col   = c[c3rb_pkg::COL_OUT_W-1:0];
                    res.row   = r[c3rb_pkg::ROW_OUT_W-1:0];
                    res.last  = 1'b0;
                    res.eof   = (c == dw - 1) && (r == dh - 1);
                    conv_expect_q.push_back(res);
                    n++;
                end
            end
        end
        if (n > 0) conv_expect_q[$].last = 1'b1;
        if (pcol >= w - 1)
        begin
            pcol = 0;
            prow = (prow >= h - 1) ? 0 : prow + 1;
        end
        else
            pcol++;
    endtask

    // Pixel driver: hold a request until taken, then wait a drawn gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel    <= '0;
            in_gap   <= 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_gap > 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pixel_q.size() > 0)
            begin
                pixel    <= pixel_q.pop_front();
                in_valid <= 1'b1;
                in_gap   <= gap_draw();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor: stall at random, compare each result with the oldest sum
    always @(posedge clk or negedge rst_n)
    begin
        conv_result_t exp_res;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (conv_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result value=%0d col=%0d row=%0d",
                             $time, value, out_col, out_row);
                    errors++;
                end
                else
                begin
                    exp_res = conv_expect_q.pop_front();
                    if (value !== exp_res.value)
                    begin
                        $display("%0t: value expected %0d actual %0d",
                                 $time, exp_res.value, value);
                        errors++;
                    end
                    if (out_col !== exp_res.col)
                    begin
                        $display("%0t: out_col expected %0d actual %0d",
                                 $time, exp_res.col, out_col);
                        errors++;
                    end
                    if (out_row !== exp_res.row)
                    begin
                        $display("%0t: out_row expected %0d actual %0d",
                                 $time, exp_res.row, out_row);
                        errors++;
                    end
                    if (last_of_run !== exp_res.last)
                    begin
                        $display("%0t: last_of_run expected %0b actual %0b",
                                 $time, exp_res.last, last_of_run);
                        errors++;
                    end
                    if (end_of_frame !== exp_res.eof)
                    begin
                        $display("%0t: end_of_frame expected %0b actual %0b",
                                 $time, exp_res.eof, end_of_frame);
                        errors++;
                    end
                end
                out_stall <= gap_draw();
                out_ready <= 1'b0;
            end
            else if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Wait until every request is taken and every sum has come, then drain
    task automatic wait_idle();
        while (pixel_q.size() > 0 || in_valid || conv_expect_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic reg_write(input c3rb_pkg::cfg_reg_t idx,
                             input logic [c3rb_pkg::KROW_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            c3rb_pkg::REG_KERNEL_TOP:    krow[0] = data;
            c3rb_pkg::REG_KERNEL_MID:    krow[1] = data;
            c3rb_pkg::REG_KERNEL_BOTTOM: krow[2] = data;
            c3rb_pkg::REG_SOURCE_WIDTH:  src_w = int'(data[10:0]);
            c3rb_pkg::REG_SOURCE_HEIGHT: src_h = int'(data[12:0]);
            c3rb_pkg::REG_DEST_WIDTH:    dst_w = int'(data[10:0]);
            c3rb_pkg::REG_DEST_HEIGHT:   dst_h = int'(data[12:0]);
            default: ;
        endcase
    endtask

    task automatic set_sizes(input int sw, input int sh, input int dw, input int dh);
        reg_write(c3rb_pkg::REG_SOURCE_WIDTH, c3rb_pkg::KROW_W'(sw));
        reg_write(c3rb_pkg::REG_SOURCE_HEIGHT, c3rb_pkg::KROW_W'(sh));
        reg_write(c3rb_pkg::REG_DEST_WIDTH, c3rb_pkg::KROW_W'(dw));
        reg_write(c3rb_pkg::REG_DEST_HEIGHT, c3rb_pkg::KROW_W'(dh));
    endtask

    function automatic logic signed [c3rb_pkg::PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return c3rb_pkg::PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [c3rb_pkg::KROW_W-1:0] pick_krow();
        logic [c3rb_pkg::KROW_W-1:0] k;
        for (int kc = 0; kc < 3; kc++)
        begin
            case ($urandom_range(0, 5))
                0: k[16*kc +: 16] = 16'h8000;
                1: k[16*kc +: 16] = 16'h7fff;
                default: k[16*kc +: 16] = 16'($urandom);
            endcase
        end
        return k;
    endfunction

    task automatic send_pixel(input logic signed [c3rb_pkg::PIX_W-1:0] p);
        conv_predict(p);
        pixel_q.push_back(p);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) send_pixel(pick_pixel());
    endtask

    // Feed pixels until the stream stands at the top-left corner again
    task automatic finish_frame();
        while (!(pcol == 0 && prow == 0)) send_pixel(pick_pixel());
    endtask

    initial
    begin
        int rand_sent, n;
        krow[0] = '0;
        krow[1] = 48'h0000_4000_0000;
        krow[2] = '0;
        src_w = MAXW; src_h = MAXH; dst_w = MAXW; dst_h = MAXH;
        pcol = 0; prow = 0;
        for (int i = 0; i < 2*MAXW; i++) lstore[i] = '0;
        for (int i = 0; i < 9; i++) win[i/3][i%3] = '0;
        errors = 0; cycles = 0; calm = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme coefficients on a small frame with extreme pixels
        reg_write(c3rb_pkg::REG_KERNEL_TOP, 48'h8000_8000_8000);
        reg_write(c3rb_pkg::REG_KERNEL_MID, 48'h7fff_7fff_7fff);
        reg_write(c3rb_pkg::REG_KERNEL_BOTTOM, 48'h8000_7fff_0000);
        set_sizes(4, 3, 4, 3);
        for (int i = 0; i < 12; i++)
            send_pixel(i % 3 == 0 ? 16'sh8000 : (i % 3 == 1 ? 16'sh7fff : -16'sd1));
        wait_idle();

        // Zero source size acts as one pixel
        set_sizes(0, 0, 1, 1);
        send_pixel(16'sh7fff);
        send_pixel(16'sh8000);
        send_pixel(16'sh0001);
        wait_idle();

        // Empty destination, then destination beyond the source
        set_sizes(3, 2, 0, 2);
        send_random(6);
        wait_idle();
        set_sizes(3, 2, 5, 7);
        send_random(6);
        wait_idle();

        // Shrink the source mid-frame
        set_sizes(6, 5, 6, 5);
        send_random(10);
        wait_idle();
        set_sizes(3, 2, 3, 2);
        finish_frame();
        wait_idle();

        // Oversize width register, start of a long single row
        reg_write(c3rb_pkg::REG_KERNEL_TOP, pick_krow());
        set_sizes(2047, 1, 2047, 1);
        send_random(EDGE_ITEMS);
        wait_idle();

        // Oversize height register, then shrink the height mid-frame
        set_sizes(1, 8191, 1, 8191);
        send_random(EDGE_ITEMS);
        wait_idle();
        send_random(20);
        wait_idle();
        reg_write(c3rb_pkg::REG_SOURCE_HEIGHT, 48'd3);
        finish_frame();
        wait_idle();

        // Random kernels and sizes, whole frames with random content
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            reg_write(c3rb_pkg::REG_KERNEL_TOP, pick_krow());
            reg_write(c3rb_pkg::REG_KERNEL_MID, pick_krow());
            reg_write(c3rb_pkg::REG_KERNEL_BOTTOM, pick_krow());
            set_sizes($urandom_range(0, 9), $urandom_range(0, 7),
                      $urandom_range(0, 11), $urandom_range(0, 9));
            n = $urandom_range(5, 40);
            send_random(n);
            rand_sent += n;
            while (!(pcol == 0 && prow == 0))
            begin
                send_pixel(pick_pixel());
                rand_sent++;
            end
            wait_idle();
        end

        calm = 1'b0;
        wait_idle();
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
